### rtl/plu_pkg.sv
// Shared types, constants and helper functions of the particle life update block.
`default_nettype none

package plu_pkg;

  // Default number of fraction bits of the Qm.f position, velocity and time formats.
  localparam int unsigned FracBitsDef = 16;
  // Depth of the queue between the front and the back.
  localparam int unsigned FifoDepthDef = 4;
  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  // Long division: quotient bits and working width of the remainder.
  localparam int unsigned DivQW = 17;
  localparam int unsigned DivDW = 50;
  // One in Q1.16.
  localparam logic [16:0] One16 = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP    = 3'd0,
    CFG_GRAVITY_X    = 3'd1,
    CFG_GRAVITY_Y    = 3'd2,
    CFG_GRAVITY_Z    = 3'd3,
    CFG_DAMPING      = 3'd4,
    CFG_GROWTH_SCALE = 3'd5,
    CFG_LIFETIME     = 3'd6,
    CFG_FADE         = 3'd7
  } cfg_idx_e;

  // How the opacity of an item is formed after the divisions.
  typedef enum logic [3:0] {
    ASEL_BLEND_RATIO = 4'b0001,
    ASEL_DIV         = 4'b0010,
    ASEL_BLEND_DIV   = 4'b0100,
    ASEL_START       = 4'b1000
  } asel_e;

  // Configuration registers as seen by both halves.
  typedef struct packed {
    logic [24:0]      ts;
    logic [2:0][31:0] grav;
    logic [16:0]      dmp;
    logic [25:0]      gs;
    logic [31:0]      life;
    logic [16:0]      fade;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [32:0]      rad;
    logic [31:0]      age;
    logic [31:0]      life;
    logic [16:0]      a1;
    logic [16:0]      a2;
    logic [16:0]      fd;
    logic             moving;
    logic             alive;
  } fe_t;

  // Working record of the back pipeline ahead of the dividers.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] nv;
    logic [2:0][56:0] gp;
    logic [2:0][48:0] mp;
    logic [32:0]      rad;
    logic [31:0]      age;
    logic [31:0]      life;
    logic [16:0]      a1;
    logic [16:0]      a2;
    logic [16:0]      fd;
    logic             moving;
    logic             alive;
    logic [47:0]      dd;
    logic [47:0]      n1;
    logic [47:0]      n2;
    logic [49:0]      den;
    asel_e            asel;
    logic [49:0]      dv_hi;
    logic [16:0]      dv_lo;
    logic [49:0]      dv_d;
    logic [49:0]      rt_hi;
    logic [16:0]      rt_lo;
    logic [49:0]      rt_d;
  } bk_t;

  // Fields that ride alongside the divisions.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [32:0]      rad;
    logic [31:0]      age;
    logic [16:0]      a1;
    logic [16:0]      a2;
    asel_e            asel;
    logic             alive;
  } sd_t;

  // Saturate a fraction to one.
  function automatic logic [16:0] clamp_one(input logic [16:0] v);
    logic [16:0] r;
    r = (v > One16) ? One16 : v;
    return r;
  endfunction

  // Saturate a wide signed sum to 32 bits.
  function automatic logic [31:0] sat32(input logic signed [57:0] x);
    logic [31:0] r;
    if (x > 58'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (x < -58'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/plu_if.sv
// Channel interfaces of the particle life update block: input, output and configuration.
`default_nettype none

interface plu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic [32:0]        radius;
  logic [31:0]        age;
  logic [16:0]        alpha_start;
  logic [16:0]        alpha_end;
  logic               use_end_alpha;
  logic               moving;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, age,
                  alpha_start, alpha_end, use_end_alpha, moving, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, age,
                alpha_start, alpha_end, use_end_alpha, moving, output ready);
endinterface

interface plu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic [32:0]        new_radius;
  logic [31:0]        new_age;
  logic [16:0]        opacity;
  logic [16:0]        life_ratio;
  logic               alive;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, new_radius, new_age, opacity, life_ratio, alive, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, new_radius, new_age, opacity, life_ratio, alive, output ready);
endinterface

interface plu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [plu_pkg::CfgIdxW-1:0]  idx;
  logic [plu_pkg::CfgDataW-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

### rtl/particle_life_update_top.sv
// Top level of the particle life update block: front, queue and back.
//
// One input beat carries one particle's state; one output beat carries its state
// after one time step (scaled radius, advanced age, opacity, life ratio, and new
// position and velocity for moving particles). Dead particles come out as zeros.
// Configuration registers are written through cfg_i, index and data per beat;
// the user must write them only while no item is in flight, as the block does
// not enforce it; the port is always ready. Throughput is one particle per
// cycle while the output is not stalled; the depth is set mostly by the
// 17-stage long division that forms opacity and life ratio in parallel.
// The front captures and classifies items and feeds a small queue; the back
// pipeline advances only while its output register is free or being read, so a
// stalled receiver first fills the queue and then drops in_i.ready.
// Reset empties the pipeline and loads the register defaults.
`default_nettype none

module particle_life_update_top #(
  parameter int unsigned FracBits  = plu_pkg::FracBitsDef,
  parameter int unsigned FifoDepth = plu_pkg::FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plu_in_if.sink     in_i,
  plu_cfg_if.sink    cfg_i,
  plu_out_if.source  out_o
);

  plu_pkg::cfg_t cfg;
  plu_pkg::fe_t  push_entry, pop_entry;
  logic          push, pop, full, empty;

  plu_front #(
    .FracBits (FracBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .cfg_o   (cfg),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  plu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  plu_back #(
    .FracBits (FracBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### rtl/plu_front.sv
// Front half: configuration registers, input beat capture, radius and age update, kill check.
`default_nettype none

module plu_front #(
  parameter int unsigned FracBits = plu_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  plu_in_if.sink         in_i,
  plu_cfg_if.sink        cfg_i,
  output plu_pkg::cfg_t  cfg_o,
  output logic           push_o,
  output plu_pkg::fe_t   entry_o,
  input  logic           full_i
);

  localparam logic [63:0] MinRad = 64'(((64'd1 << FracBits) + 64'd99) / 64'd100);
  localparam logic [63:0] MaxRad = 64'd100000 << FracBits;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [58:0]      rprod;
    logic [32:0]      age_s;
    logic [31:0]      life;
    logic [16:0]      a1;
    logic [16:0]      a2;
    logic [16:0]      fd;
    logic             moving;
  } ft_t;

  plu_pkg::cfg_t cfg_q;
  ft_t           ft_q, ft_d;
  logic          fvld_q;
  logic          accept;
  logic [58:0]   rshift;
  logic [32:0]   rad;
  logic [31:0]   age;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ts   <= 25'd1092;
      cfg_q.grav <= '0;
      cfg_q.dmp  <= 17'd0;
      cfg_q.gs   <= 26'd66191;
      cfg_q.life <= 32'd131072;
      cfg_q.fade <= 17'd65536;
    end else if (cfg_i.valid) begin
      unique case (plu_pkg::cfg_idx_e'(cfg_i.idx))
        plu_pkg::CFG_TIME_STEP:    cfg_q.ts      <= cfg_i.data[24:0];
        plu_pkg::CFG_GRAVITY_X:    cfg_q.grav[0] <= cfg_i.data;
        plu_pkg::CFG_GRAVITY_Y:    cfg_q.grav[1] <= cfg_i.data;
        plu_pkg::CFG_GRAVITY_Z:    cfg_q.grav[2] <= cfg_i.data;
        plu_pkg::CFG_DAMPING:      cfg_q.dmp     <= cfg_i.data[16:0];
        plu_pkg::CFG_GROWTH_SCALE: cfg_q.gs      <= cfg_i.data[25:0];
        plu_pkg::CFG_LIFETIME:     cfg_q.life    <= cfg_i.data;
        plu_pkg::CFG_FADE:         cfg_q.fade    <= cfg_i.data[16:0];
        default:                   cfg_q.fade    <= cfg_q.fade;
      endcase
    end
  end

  // The capture stage frees up whenever its beat moves into the queue.
  assign push_o     = fvld_q && !full_i;
  assign in_i.ready = !fvld_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Capture stage: radius product, age sum and the fraction clamps.
  always_comb begin
    ft_d.pos    = {in_i.pos_z, in_i.pos_y, in_i.pos_x};
    ft_d.vel    = {in_i.vel_z, in_i.vel_y, in_i.vel_x};
    ft_d.rprod  = {26'd0, in_i.radius} * {33'd0, cfg_q.gs};
    ft_d.age_s  = {1'b0, in_i.age} + {8'd0, cfg_q.ts};
    ft_d.life   = (cfg_q.life == 32'd0) ? 32'd1 : cfg_q.life;
    ft_d.a1     = plu_pkg::clamp_one(in_i.alpha_start);
    ft_d.a2     = in_i.use_end_alpha ? plu_pkg::clamp_one(in_i.alpha_end)
                                     : plu_pkg::clamp_one(in_i.alpha_start);
    ft_d.fd     = plu_pkg::clamp_one(cfg_q.fade);
    ft_d.moving = in_i.moving;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q <= 1'b0;
    end else if (in_i.ready) begin
      fvld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ft_q <= ft_d;
    end
  end

  // Classification: saturate radius and age, then decide whether the particle lives.
  always_comb begin
    rshift = ft_q.rprod >> FracBits;
    rad    = (|rshift[58:33]) ? '1 : rshift[32:0];
    age    = ft_q.age_s[32] ? '1 : ft_q.age_s[31:0];
    entry_o.pos    = ft_q.pos;
    entry_o.vel    = ft_q.vel;
    entry_o.rad    = rad;
    entry_o.age    = age;
    entry_o.life   = ft_q.life;
    entry_o.a1     = ft_q.a1;
    entry_o.a2     = ft_q.a2;
    entry_o.fd     = ft_q.fd;
    entry_o.moving = ft_q.moving;
    entry_o.alive  = !(({31'd0, rad} < MinRad) || ({31'd0, rad} > MaxRad) ||
                       (age > ft_q.life));
  end

endmodule

`default_nettype wire

### rtl/plu_fifo.sv
// Short queue of classified items between the front and the back.
`default_nettype none

module plu_fifo #(
  parameter int unsigned Depth = plu_pkg::FifoDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  plu_pkg::fe_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output plu_pkg::fe_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  plu_pkg::fe_t    slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/plu_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none

module plu_div #(
  parameter int unsigned DW = plu_pkg::DivDW,
  parameter int unsigned QW = plu_pkg::DivQW,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [1:0][DW-1:0]  hi_i,
  input  logic [1:0][QW-1:0]  lo_i,
  input  logic [1:0][DW-1:0]  d_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [1:0][QW-1:0]  q_o,
  output logic [SW-1:0]       side_o
);

  logic [QW:0]                vld;
  logic [QW:0][1:0][DW-1:0]   rem;
  logic [QW:0][1:0][DW-1:0]   dv;
  logic [QW:0][1:0][QW-1:0]   lo;
  logic [QW:0][1:0][QW-1:0]   qt;
  logic [QW:0][SW-1:0]        side;

  // The upper dividend part must be below the divisor.
  assign vld[0]  = vld_i;
  assign rem[0]  = hi_i;
  assign dv[0]   = d_i;
  assign lo[0]   = lo_i;
  assign qt[0]   = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [1:0][DW:0]   trial;
    logic [1:0][DW-1:0] rem_d;
    logic [1:0][QW-1:0] q_d;

    // Shift in the next dividend bit, subtract the divisor where it fits.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem[k][l], lo[k][l][QW-1]};
        if (trial[l] >= {1'b0, dv[k][l]}) begin
          rem_d[l] = DW'(trial[l] - {1'b0, dv[k][l]});
          q_d[l]   = {qt[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[l][DW-1:0];
          q_d[l]   = {qt[k][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= rem_d;
        dv[k+1]   <= dv[k];
        lo[k+1]   <= {lo[k][1][QW-2:0], 1'b0, lo[k][0][QW-2:0], 1'b0};
        qt[k+1]   <= q_d;
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_o  = vld[QW];
  assign q_o    = qt[QW];
  assign side_o = side[QW];

endmodule

`default_nettype wire

### rtl/plu_back.sv
// Back half: motion update, opacity and life ratio divisions, blend and output register.
`default_nettype none

module plu_back #(
  parameter int unsigned FracBits = plu_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  plu_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  plu_pkg::fe_t  entry_i,
  output logic          pop_o,
  plu_out_if.source     out_o
);

  localparam int unsigned SdW = $bits(plu_pkg::sd_t);

  typedef struct packed {
    plu_pkg::sd_t sd;
    logic [16:0]  ratio;
    logic [16:0]  q0;
    logic [33:0]  prod;
    logic         up;
  } pb_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [32:0]      rad;
    logic [31:0]      age;
    logic [16:0]      opacity;
    logic [16:0]      ratio;
    logic             alive;
  } ob_t;

  logic               en;
  logic [16:0]        dmpc;
  plu_pkg::bk_t       s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  logic               v1_q, v2_q, v3_q, v4_q;
  plu_pkg::sd_t       sd_in, sd_out;
  logic [SdW-1:0]     side_out;
  logic [1:0][49:0]   dhi, dd;
  logic [1:0][16:0]   dlo;
  logic [1:0][16:0]   dq;
  logic               dvld;
  pb_t                p1_q, p1_d;
  logic               p1v_q;
  ob_t                ob_q, ob_d;
  logic               ov_q;

  // The whole back pipeline moves unless a finished result waits at the output and is not being read.
  assign en    = !ov_q || out_o.ready;
  assign pop_o = en && !empty_i;
  assign dmpc  = plu_pkg::clamp_one(cfg_i.dmp);

  // Stage 1: gravity terms and the products that set up the divisions.
  always_comb begin
    s1_d        = '0;
    s1_d.pos    = entry_i.pos;
    s1_d.vel    = entry_i.vel;
    s1_d.nv     = entry_i.vel;
    s1_d.rad    = entry_i.rad;
    s1_d.age    = entry_i.age;
    s1_d.life   = entry_i.life;
    s1_d.a1     = entry_i.a1;
    s1_d.a2     = entry_i.a2;
    s1_d.fd     = entry_i.fd;
    s1_d.moving = entry_i.moving;
    s1_d.alive  = entry_i.alive;
    s1_d.asel   = plu_pkg::ASEL_START;
    for (int i = 0; i < 3; i++) begin
      s1_d.gp[i] = $signed({{25{cfg_i.grav[i][31]}}, cfg_i.grav[i]}) *
                   $signed({32'd0, cfg_i.ts});
    end
    s1_d.dd  = {31'd0, entry_i.fd} * {16'd0, entry_i.life};
    s1_d.n1  = {31'd0, entry_i.a1} * {16'd0, entry_i.age};
    s1_d.n2  = {31'd0, entry_i.a2} * {16'd0, 32'(entry_i.life - entry_i.age)};
    s1_d.den = ({33'd0, 17'(plu_pkg::One16 - entry_i.fd)} * {18'd0, entry_i.life}) << 1;
  end

  // Stage 2: velocity plus gravity, opacity case choice and divider operands.
  always_comb begin
    logic signed [57:0] gsh;
    logic [48:0]        x;
    logic [48:0]        num;
    s2_d = s1_q;
    for (int i = 0; i < 3; i++) begin
      gsh        = $signed({s1_q.gp[i][56], s1_q.gp[i]}) >>> FracBits;
      s2_d.nv[i] = plu_pkg::sat32($signed({{26{s1_q.vel[i][31]}}, s1_q.vel[i]}) + gsh);
    end
    x     = {s1_q.age, 17'd0};
    num   = 49'(x - {1'b0, s1_q.dd});
    s2_d.dv_hi = '0;
    s2_d.dv_lo = '0;
    s2_d.dv_d  = 50'd1;
    if (s1_q.fd == '0) begin
      s2_d.asel = plu_pkg::ASEL_BLEND_RATIO;
    end else if (x < {1'b0, s1_q.dd}) begin
      s2_d.asel  = plu_pkg::ASEL_DIV;
      s2_d.dv_hi = {2'd0, s1_q.n1};
      s2_d.dv_d  = {2'd0, s1_q.dd};
    end else if ({32'(s1_q.life - s1_q.age), 17'd0} <= {1'b0, s1_q.dd}) begin
      s2_d.asel  = plu_pkg::ASEL_DIV;
      s2_d.dv_hi = {2'd0, s1_q.n2};
      s2_d.dv_d  = {2'd0, s1_q.dd};
    end else if ((s1_q.den != '0) && ({1'b0, num} < s1_q.den)) begin
      s2_d.asel  = plu_pkg::ASEL_BLEND_DIV;
      s2_d.dv_hi = {2'd0, num[48:1]};
      s2_d.dv_lo = {num[0], 16'd0};
      s2_d.dv_d  = s1_q.den;
    end else begin
      s2_d.asel = plu_pkg::ASEL_START;
    end
    // Life ratio: age shifted up by sixteen over the lifetime.
    s2_d.rt_hi = {19'd0, s1_q.age[31:1]};
    s2_d.rt_lo = {s1_q.age[0], 16'd0};
    s2_d.rt_d  = {18'd0, s1_q.life};
  end

  // Stage 3: damping product.
  always_comb begin
    s3_d = s2_q;
    for (int i = 0; i < 3; i++) begin
      s3_d.mp[i] = $signed({{17{s2_q.nv[i][31]}}, s2_q.nv[i]}) *
                   $signed({31'd0, 18'(plu_pkg::One16 - dmpc)});
    end
  end

  // Stage 4: damped velocity and its displacement over one step.
  always_comb begin
    logic signed [48:0] msh;
    s4_d = s3_q;
    for (int i = 0; i < 3; i++) begin
      msh = $signed(s3_q.mp[i]) >>> 16;
      if (dmpc != '0) begin
        s4_d.nv[i] = msh[31:0];
      end
      s4_d.gp[i] = $signed({{25{s4_d.nv[i][31]}}, s4_d.nv[i]}) *
                   $signed({32'd0, cfg_i.ts});
    end
  end

  // Position update and the record that travels with the divisions.
  always_comb begin
    logic signed [57:0] psh;
    sd_in.rad   = s4_q.rad;
    sd_in.age   = s4_q.age;
    sd_in.a1    = s4_q.a1;
    sd_in.a2    = s4_q.a2;
    sd_in.asel  = s4_q.asel;
    sd_in.alive = s4_q.alive;
    for (int i = 0; i < 3; i++) begin
      psh = $signed({s4_q.gp[i][56], s4_q.gp[i]}) >>> FracBits;
      if (s4_q.moving) begin
        sd_in.pos[i] = plu_pkg::sat32($signed({{26{s4_q.pos[i][31]}}, s4_q.pos[i]}) + psh);
        sd_in.vel[i] = s4_q.nv[i];
      end else begin
        sd_in.pos[i] = s4_q.pos[i];
        sd_in.vel[i] = s4_q.vel[i];
      end
    end
    dhi = {s4_q.rt_hi, s4_q.dv_hi};
    dlo = {s4_q.rt_lo, s4_q.dv_lo};
    dd  = {s4_q.rt_d, s4_q.dv_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  // Lane 0 forms the opacity quotient, lane 1 the life ratio.
  plu_div #(
    .DW (plu_pkg::DivDW),
    .QW (plu_pkg::DivQW),
    .SW (SdW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .hi_i   (dhi),
    .lo_i   (dlo),
    .d_i    (dd),
    .side_i (sd_in),
    .vld_o  (dvld),
    .q_o    (dq),
    .side_o (side_out)
  );

  assign sd_out = side_out;

  // Blend product toward the end alpha.
  always_comb begin
    logic [16:0] r;
    logic [16:0] diff;
    p1_d.sd    = sd_out;
    p1_d.ratio = dq[1];
    p1_d.q0    = dq[0];
    p1_d.up    = sd_out.a2 >= sd_out.a1;
    r          = (sd_out.asel == plu_pkg::ASEL_BLEND_RATIO) ? dq[1] : dq[0];
    diff       = p1_d.up ? 17'(sd_out.a2 - sd_out.a1) : 17'(sd_out.a1 - sd_out.a2);
    p1_d.prod  = {17'd0, diff} * {17'd0, r};
  end

  // Final opacity and the zeroed record of a dead particle.
  always_comb begin
    logic [16:0] step;
    logic [16:0] op;
    step = p1_q.prod[32:16];
    unique case (p1_q.sd.asel)
      plu_pkg::ASEL_BLEND_RATIO,
      plu_pkg::ASEL_BLEND_DIV: op = p1_q.up ? 17'(p1_q.sd.a1 + step) : 17'(p1_q.sd.a1 - step);
      plu_pkg::ASEL_DIV:       op = p1_q.q0;
      default:                 op = p1_q.sd.a1;
    endcase
    if (p1_q.sd.alive) begin
      ob_d.pos     = p1_q.sd.pos;
      ob_d.vel     = p1_q.sd.vel;
      ob_d.rad     = p1_q.sd.rad;
      ob_d.age     = p1_q.sd.age;
      ob_d.opacity = op;
      ob_d.ratio   = p1_q.ratio;
      ob_d.alive   = 1'b1;
    end else begin
      ob_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else if (en) begin
      p1v_q <= dvld;
      ov_q  <= p1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      ob_q <= ob_d;
    end
  end

  // Output beat.
  assign out_o.valid      = ov_q;
  assign out_o.new_pos_x  = ob_q.pos[0];
  assign out_o.new_pos_y  = ob_q.pos[1];
  assign out_o.new_pos_z  = ob_q.pos[2];
  assign out_o.new_vel_x  = ob_q.vel[0];
  assign out_o.new_vel_y  = ob_q.vel[1];
  assign out_o.new_vel_z  = ob_q.vel[2];
  assign out_o.new_radius = ob_q.rad;
  assign out_o.new_age    = ob_q.age;
  assign out_o.opacity    = ob_q.opacity;
  assign out_o.life_ratio = ob_q.ratio;
  assign out_o.alive      = ob_q.alive;

endmodule

`default_nettype wire
